// ===== rtl/ssft_pkg.sv =====
package ssft_pkg;

  localparam int DIGITS      = 6;
  localparam int BYTE_BITS   = 8;
  localparam int FRAME_BYTES = DIGITS + 3;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WRITE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CONTROL = 2'd2;

  localparam logic [7:0] CMD_DATA_WRITE_RST      = 8'h40;
  localparam logic [7:0] CMD_START_ADDRESS_RST   = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_CONTROL_RST = 8'h8F;

  typedef struct packed {
    logic       req_type;
    logic [2:0] digit_index;
    logic [7:0] digit_value;
    logic       last_digit;
  } item_t;

  typedef struct packed {
    logic [7:0] data_write;
    logic [7:0] start_address;
    logic [7:0] display_control;
  } cmd_t;

  typedef struct packed {
    logic clk_level;
    logic data_level;
    logic busy_res;
  } pins_t;

endpackage

// ===== rtl/ssft_in_if.sv =====
interface ssft_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [2:0] digit_index;
  logic [7:0] digit_value;
  logic       last_digit;

  modport source (output valid, req_type, digit_index, digit_value, last_digit,
                  input ready);
  modport sink   (input valid, req_type, digit_index, digit_value, last_digit,
                  output ready);
endinterface

// ===== rtl/ssft_out_if.sv =====
interface ssft_out_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic data_level;
  logic busy_res;

  modport source (output valid, clk_level, data_level, busy_res, input ready);
  modport sink   (input valid, clk_level, data_level, busy_res, output ready);
endinterface

// ===== rtl/ssft_cfg_if.sv =====
interface ssft_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ssft_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ssft_seq.sv =====
module ssft_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  ssft_pkg::item_t item,
  input  ssft_pkg::cmd_t  cmds,
  output ssft_pkg::pins_t res_nxt
);
  import ssft_pkg::*;

  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_IDLE      = 4'd1;
  localparam logic [3:0] PH_SB_BEGIN  = 4'd2;
  localparam logic [3:0] PH_SB_END    = 4'd3;
  localparam logic [3:0] PH_BIT_OUT   = 4'd4;
  localparam logic [3:0] PH_BIT_CLK   = 4'd5;
  localparam logic [3:0] PH_BIT_NEXT  = 4'd6;
  localparam logic [3:0] PH_DATA_END  = 4'd7;
  localparam logic [3:0] PH_ACK_LOW   = 4'd8;
  localparam logic [3:0] PH_ACK_HIGH  = 4'd9;
  localparam logic [3:0] PH_ACK_END   = 4'd10;
  localparam logic [3:0] PH_SP_BEGIN  = 4'd11;
  localparam logic [3:0] PH_SP_END    = 4'd12;
  localparam logic [3:0] PH_NEXT_BYTE = 4'd13;
  localparam logic [3:0] PH_STOP      = 4'd14;

  logic [3:0] phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [3:0] byte_cnt_r, byte_cnt_nxt;
  logic       pending_r, pending_nxt;
  logic       clk_pin_r, clk_pin_nxt;
  logic       data_pin_r, data_pin_nxt;
  logic [7:0] store_r   [DIGITS];
  logic [7:0] store_nxt [DIGITS];

  logic [7:0] slot_byte;
  logic       slot_start;
  logic       slot_stop;

  // byte, start and stop flags of the current frame slot
  always_comb begin
    slot_byte = 8'h00;
    if (byte_cnt_r == 4'd0) begin
      slot_byte = cmds.data_write;
    end else if (byte_cnt_r == 4'd1) begin
      slot_byte = cmds.start_address;
    end else if (byte_cnt_r == 4'(DIGITS + 2)) begin
      slot_byte = cmds.display_control;
    end
    for (int i = 0; i < DIGITS; i++) begin
      if (byte_cnt_r == 4'(i + 2)) begin
        slot_byte = store_r[i];
      end
    end
    slot_start = (byte_cnt_r == 4'd1) || (byte_cnt_r == 4'(DIGITS + 2));
    slot_stop  = (byte_cnt_r == 4'd0) || (byte_cnt_r == 4'(DIGITS + 1)) ||
                 (byte_cnt_r == 4'(DIGITS + 2));
  end

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    pending_nxt  = pending_r;
    clk_pin_nxt  = clk_pin_r;
    data_pin_nxt = data_pin_r;
    for (int i = 0; i < DIGITS; i++) begin
      store_nxt[i] = store_r[i];
    end

    if (item.req_type) begin
      // load: pins and phase hold
      for (int i = 0; i < DIGITS; i++) begin
        if (item.digit_index == 3'(i)) begin
          store_nxt[i] = item.digit_value;
        end
      end
      if (item.last_digit) begin
        pending_nxt = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (pending_r) begin
            clk_pin_nxt  = 1'b0;
            data_pin_nxt = 1'b0;
            phase_nxt    = PH_SB_BEGIN;
          end
        end
        PH_SB_BEGIN: begin
          if (slot_start) begin
            clk_pin_nxt  = 1'b1;
            data_pin_nxt = 1'b1;
            phase_nxt    = PH_SB_END;
          end else begin
            clk_pin_nxt  = 1'b0;
            data_pin_nxt = 1'b0;
            phase_nxt    = PH_BIT_OUT;
          end
        end
        PH_SB_END: begin
          clk_pin_nxt  = 1'b0;
          data_pin_nxt = 1'b0;
          phase_nxt    = PH_BIT_OUT;
        end
        PH_BIT_OUT: begin
          clk_pin_nxt  = 1'b0;
          data_pin_nxt = bit_cnt_r[3] ? 1'b0 : slot_byte[bit_cnt_r[2:0]];
          phase_nxt    = PH_BIT_CLK;
        end
        PH_BIT_CLK: begin
          clk_pin_nxt = 1'b1;
          phase_nxt   = PH_BIT_NEXT;
        end
        PH_BIT_NEXT: begin
          bit_cnt_nxt = bit_cnt_r + 4'd1;
          if (bit_cnt_nxt >= 4'(BYTE_BITS)) begin
            clk_pin_nxt = 1'b0;
            phase_nxt   = PH_DATA_END;
          end else begin
            phase_nxt = PH_BIT_OUT;
          end
        end
        PH_DATA_END: begin
          data_pin_nxt = 1'b0;
          phase_nxt    = PH_ACK_LOW;
        end
        PH_ACK_LOW: begin
          clk_pin_nxt = 1'b0;
          phase_nxt   = PH_ACK_HIGH;
        end
        PH_ACK_HIGH: begin
          clk_pin_nxt = 1'b1;
          phase_nxt   = PH_ACK_END;
        end
        PH_ACK_END: begin
          clk_pin_nxt = 1'b0;
          phase_nxt   = PH_SP_BEGIN;
        end
        PH_SP_BEGIN: begin
          if (slot_stop) begin
            data_pin_nxt = 1'b1;
            phase_nxt    = PH_SP_END;
          end else begin
            phase_nxt = PH_NEXT_BYTE;
          end
        end
        PH_SP_END: begin
          data_pin_nxt = 1'b0;
          phase_nxt    = PH_NEXT_BYTE;
        end
        PH_NEXT_BYTE: begin
          byte_cnt_nxt = byte_cnt_r + 4'd1;
          bit_cnt_nxt  = 4'd0;
          phase_nxt    = (byte_cnt_nxt >= 4'(FRAME_BYTES)) ? PH_STOP : PH_SB_BEGIN;
        end
        PH_STOP: begin
          clk_pin_nxt  = 1'b1;
          data_pin_nxt = 1'b1;
          phase_nxt    = PH_START;
        end
        default: begin
          // start phase and the unused code: wipe the frame
          for (int i = 0; i < DIGITS; i++) begin
            store_nxt[i] = 8'h00;
          end
          bit_cnt_nxt  = 4'd0;
          byte_cnt_nxt = 4'd0;
          pending_nxt  = 1'b0;
          clk_pin_nxt  = 1'b1;
          data_pin_nxt = 1'b1;
          phase_nxt    = PH_IDLE;
        end
      endcase
    end

    res_nxt.clk_level  = clk_pin_nxt;
    res_nxt.data_level = data_pin_nxt;
    res_nxt.busy_res   = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      bit_cnt_r  <= 4'd0;
      byte_cnt_r <= 4'd0;
      pending_r  <= 1'b0;
      clk_pin_r  <= 1'b1;
      data_pin_r <= 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
        store_r[i] <= 8'h00;
      end
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      pending_r  <= pending_nxt;
      clk_pin_r  <= clk_pin_nxt;
      data_pin_r <= data_pin_nxt;
      for (int i = 0; i < DIGITS; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/seven_segment_serial_frame_tx.sv =====
// Channel   | Dir | Payload                                          | Accepted when
// in_chan   | in  | req_type, digit_index, digit_value, last_digit   | valid & ready
// out_chan  | out | clk_level, data_level, busy_res                  | valid & ready
// cfg_chan  | in  | index (0 data write, 1 address, 2 display), data | valid & ready
//
// One item a cycle while results are taken: the sequencer step and next pin levels are worked
// out combinationally into the result register; each result is valid in the next cycle.
// in_chan stays ready while the result register is empty or being drained this cycle.
// A stalled result holds the register and stops further items until it is taken.
// Reset (rst_n low, synchronous) puts the sequencer in its start phase with both pins high.
module seven_segment_serial_frame_tx (
  input logic        clk,
  input logic        rst_n,
  ssft_in_if.sink    in_chan,
  ssft_out_if.source out_chan,
  ssft_cfg_if.sink   cfg_chan
);
  import ssft_pkg::*;

  cmd_t  cmds_r;
  item_t item;
  pins_t res_nxt;
  pins_t res_r;
  logic  out_valid_r;
  logic  in_acc;
  logic  cfg_acc;

  assign in_chan.ready  = rst_n && (!out_valid_r || out_chan.ready);
  assign cfg_chan.ready = rst_n;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;

  assign item.req_type    = in_chan.req_type;
  assign item.digit_index = in_chan.digit_index;
  assign item.digit_value = in_chan.digit_value;
  assign item.last_digit  = in_chan.last_digit;

  ssft_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_acc),
    .item    (item),
    .cmds    (cmds_r),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmds_r.data_write      <= CMD_DATA_WRITE_RST;
      cmds_r.start_address   <= CMD_START_ADDRESS_RST;
      cmds_r.display_control <= CMD_DISPLAY_CONTROL_RST;
      out_valid_r            <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_chan.index)
          CFG_DATA_WRITE:      cmds_r.data_write      <= cfg_chan.data;
          CFG_START_ADDRESS:   cmds_r.start_address   <= cfg_chan.data;
          CFG_DISPLAY_CONTROL: cmds_r.display_control <= cfg_chan.data;
          default: ;
        endcase
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.clk_level  = res_r.clk_level;
  assign out_chan.data_level = res_r.data_level;
  assign out_chan.busy_res   = res_r.busy_res;

endmodule

// ===== rtl/ssft_checker.sv =====
module ssft_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic clk_level,
  input logic data_level,
  input logic busy_res
);

  // every accepted item yields a result in the next cycle
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // an idle sequencer leaves both lines released high
  a_idle_lines_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> clk_level && data_level)
    else $error("idle result with a line driven low");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(clk_level) && $stable(data_level) && $stable(busy_res))
    else $error("stalled result changed");

endmodule

bind seven_segment_serial_frame_tx ssft_checker u_ssft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .clk_level  (out_chan.clk_level),
  .data_level (out_chan.data_level),
  .busy_res   (out_chan.busy_res)
);

// ===== sim/ssft_frame_checker.sv =====
module ssft_frame_checker (
  input  logic clk,
  input  logic rst_n,
  ssft_in_if   in_mon,
  ssft_out_if  out_mon,
  ssft_cfg_if  cfg_mon,
  output int   fail_count,
  output int   in_flight
);
  import ssft_pkg::*;

  typedef enum logic [3:0] {
    SEQ_RESTART     = 4'd0,
    SEQ_IDLE        = 4'd1,
    SEQ_START_BEGIN = 4'd2,
    SEQ_START_END   = 4'd3,
    SEQ_BIT_SET     = 4'd4,
    SEQ_BIT_CLK     = 4'd5,
    SEQ_BIT_ADV     = 4'd6,
    SEQ_DATA_LOW    = 4'd7,
    SEQ_ACK_LOW     = 4'd8,
    SEQ_ACK_HIGH    = 4'd9,
    SEQ_ACK_DONE    = 4'd10,
    SEQ_STOP_BEGIN  = 4'd11,
    SEQ_STOP_END    = 4'd12,
    SEQ_BYTE_ADV    = 4'd13,
    SEQ_FRAME_DONE  = 4'd14
  } seq_phase_t;

  seq_phase_t seq;
  logic [3:0] bit_idx;
  logic [3:0] slot;
  logic       armed;
  logic       clk_q;
  logic       dat_q;
  logic [7:0] segs [DIGITS];
  cmd_t       cmds;

  pins_t pins_due [$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    due_count = 0;

  assign fail_count = mismatches;
  assign in_flight  = due_count;

  task automatic report_mismatch(input string msg);
    $display("ERROR: result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] slot_byte(input logic [3:0] s);
    if (s == 4'd0) return cmds.data_write;
    if (s == 4'd1) return cmds.start_address;
    if (s >= 4'd2 && s < 4'(DIGITS + 2)) return segs[3'(s - 4'd2)];
    if (s == 4'(DIGITS + 2)) return cmds.display_control;
    return 8'h00;
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < DIGITS; i++) segs[i] = 8'h00;
    bit_idx = 4'd0;
    slot    = 4'd0;
    armed   = 1'b0;
    clk_q   = 1'b1;
    dat_q   = 1'b1;
    seq     = SEQ_IDLE;
  endtask

  task automatic advance_sequencer();
    logic [7:0] cur_byte;
    cur_byte = slot_byte(slot);
    case (seq)
      SEQ_IDLE: begin
        if (armed) begin
          clk_q = 1'b0;
          dat_q = 1'b0;
          seq   = SEQ_START_BEGIN;
        end
      end
      SEQ_START_BEGIN: begin
        // start condition only ahead of the address and display commands
        if (slot == 4'd1 || slot == 4'(DIGITS + 2)) begin
          clk_q = 1'b1;
          dat_q = 1'b1;
          seq   = SEQ_START_END;
        end else begin
          clk_q = 1'b0;
          dat_q = 1'b0;
          seq   = SEQ_BIT_SET;
        end
      end
      SEQ_START_END: begin
        clk_q = 1'b0;
        dat_q = 1'b0;
        seq   = SEQ_BIT_SET;
      end
      SEQ_BIT_SET: begin
        clk_q = 1'b0;
        dat_q = (bit_idx < BYTE_BITS) ? cur_byte[bit_idx[2:0]] : 1'b0;
        seq   = SEQ_BIT_CLK;
      end
      SEQ_BIT_CLK: begin
        clk_q = 1'b1;
        seq   = SEQ_BIT_ADV;
      end
      SEQ_BIT_ADV: begin
        bit_idx = bit_idx + 4'd1;
        if (bit_idx >= BYTE_BITS) begin
          clk_q = 1'b0;
          seq   = SEQ_DATA_LOW;
        end else begin
          seq = SEQ_BIT_SET;
        end
      end
      SEQ_DATA_LOW: begin
        dat_q = 1'b0;
        seq   = SEQ_ACK_LOW;
      end
      SEQ_ACK_LOW: begin
        clk_q = 1'b0;
        seq   = SEQ_ACK_HIGH;
      end
      SEQ_ACK_HIGH: begin
        clk_q = 1'b1;
        seq   = SEQ_ACK_DONE;
      end
      SEQ_ACK_DONE: begin
        clk_q = 1'b0;
        seq   = SEQ_STOP_BEGIN;
      end
      SEQ_STOP_BEGIN: begin
        if (slot == 4'd0 || slot == 4'(DIGITS + 1) || slot == 4'(DIGITS + 2)) begin
          dat_q = 1'b1;
          seq   = SEQ_STOP_END;
        end else begin
          seq = SEQ_BYTE_ADV;
        end
      end
      SEQ_STOP_END: begin
        dat_q = 1'b0;
        seq   = SEQ_BYTE_ADV;
      end
      SEQ_BYTE_ADV: begin
        slot    = slot + 4'd1;
        bit_idx = 4'd0;
        seq     = (slot >= FRAME_BYTES) ? SEQ_FRAME_DONE : SEQ_START_BEGIN;
      end
      SEQ_FRAME_DONE: begin
        clk_q = 1'b1;
        dat_q = 1'b1;
        seq   = SEQ_RESTART;
      end
      default: clear_frame();
    endcase
  endtask

  task automatic apply_item(input item_t it, output pins_t res);
    if (!it.req_type) begin
      advance_sequencer();
    end else begin
      // out-of-range slots store nothing but may still arm a frame
      if (it.digit_index < DIGITS) segs[it.digit_index] = it.digit_value;
      if (it.last_digit) armed = 1'b1;
    end
    res.clk_level  = clk_q;
    res.data_level = dat_q;
    res.busy_res   = (seq != SEQ_IDLE);
  endtask

  always @(posedge clk) begin : watch
    item_t it;
    pins_t got;
    pins_t want;
    if (!rst_n) begin
      clear_frame();
      seq  = SEQ_RESTART;
      cmds = '{CMD_DATA_WRITE_RST, CMD_START_ADDRESS_RST, CMD_DISPLAY_CONTROL_RST};
      pins_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.clk_level, out_mon.data_level, out_mon.busy_res};
        if (pins_due.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = pins_due.pop_front();
          if (got.clk_level !== want.clk_level)
            report_mismatch($sformatf("clk_level expected %0b got %0b",
                                      want.clk_level, got.clk_level));
          if (got.data_level !== want.data_level)
            report_mismatch($sformatf("data_level expected %0b got %0b",
                                      want.data_level, got.data_level));
          if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("busy_res expected %0b got %0b",
                                      want.busy_res, got.busy_res));
        end
        results_seen++;
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_DATA_WRITE:      cmds.data_write      = cfg_mon.data;
          CFG_START_ADDRESS:   cmds.start_address   = cfg_mon.data;
          CFG_DISPLAY_CONTROL: cmds.display_control = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        it = {in_mon.req_type, in_mon.digit_index, in_mon.digit_value, in_mon.last_digit};
        apply_item(it, want);
        pins_due.push_back(want);
      end
    end
    due_count = pins_due.size();
  end

endmodule

// ===== sim/tb_seven_segment_serial_frame_tx.sv =====
module tb_seven_segment_serial_frame_tx;
  import ssft_pkg::*;

  localparam int CYCLE_LIMIT = 150000;

  logic clk;
  logic rst_n;
  logic idle_on;
  logic gaps_allowed;
  int   fail_count;
  int   in_flight;
  int   cycles = 0;
  int   n_ticks;
  int   n_loads;
  int   n_writes;

  ssft_in_if  in_chan ();
  ssft_out_if out_chan ();
  ssft_cfg_if cfg_chan ();

  seven_segment_serial_frame_tx dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ssft_frame_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, in_flight);
      $display("FAILURE");
      $finish;
    end
  end

  // stall the result side in short bursts
  initial begin
    out_chan.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_chan.ready = 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance with valid still high
  task automatic put_item(input item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.req_type    = it.req_type;
    in_chan.digit_index = it.digit_index;
    in_chan.digit_value = it.digit_value;
    in_chan.last_digit  = it.last_digit;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (it.req_type) n_loads++;
    else n_ticks++;
    @(negedge clk);
  endtask

  // tick items carry junk in the unused fields
  task automatic tick_item();
    put_item(item_t'({1'b0, 3'($urandom), 8'($urandom), 1'($urandom)}));
  endtask

  task automatic load_digit(input logic [2:0] idx, input logic [7:0] val, input logic last);
    put_item(item_t'({1'b1, idx, val, last}));
  endtask

  task automatic drain();
    in_chan.valid = 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
    n_writes++;
  endtask

  task automatic set_commands(input logic [7:0] dw, input logic [7:0] sa, input logic [7:0] dc);
    write_reg(CFG_DATA_WRITE, dw);
    write_reg(CFG_START_ADDRESS, sa);
    write_reg(CFG_DISPLAY_CONTROL, dc);
  endtask

  // load a digit set, arm it most of the time, then clock the sequencer through it
  task automatic send_frame();
    logic arm;
    int   n_run;
    int   pick;
    arm     = ($urandom_range(0, 7) != 0);
    idle_on = gaps_allowed && ($urandom_range(0, 2) != 0);
    for (int i = 0; i < DIGITS; i++) begin
      if ($urandom_range(0, 9) == 0) put_item(item_t'(13'($urandom)));
      load_digit(3'(i), 8'($urandom), arm && (i == DIGITS - 1));
    end
    n_run = arm ? $urandom_range(270, 310) : $urandom_range(10, 40);
    repeat (n_run) begin
      pick = $urandom_range(0, 39);
      if (pick == 0)
        load_digit(3'($urandom_range(0, 7)), 8'($urandom), $urandom_range(0, 3) == 0);
      else if (pick == 1)
        put_item(item_t'(13'($urandom)));
      else
        tick_item();
    end
  endtask

  initial begin
    int phase_start;
    rst_n                = 1'b0;
    idle_on              = 1'b0;
    gaps_allowed         = 1'b1;
    n_ticks              = 0;
    n_loads              = 0;
    n_writes             = 0;
    in_chan.valid        = 1'b0;
    in_chan.req_type     = 1'b0;
    in_chan.digit_index  = 3'd0;
    in_chan.digit_value  = 8'h00;
    in_chan.last_digit   = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.index       = CFG_DATA_WRITE;
    cfg_chan.data        = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load before the first tick is wiped by the start phase
    load_digit(3'd0, 8'hFF, 1'b1);
    tick_item();
    tick_item();
    // a tick with last_digit set must not arm anything
    put_item(item_t'({1'b0, 3'd7, 8'hFF, 1'b1}));
    tick_item();
    load_digit(3'd5, 8'h00, 1'b0);
    load_digit(3'd6, 8'hAA, 1'b0);
    // out-of-range slot stores nothing yet still arms the frame
    load_digit(3'd7, 8'h55, 1'b1);
    load_digit(3'd0, 8'h81, 1'b0);
    repeat (12) tick_item();
    load_digit(3'd4, 8'h7E, 1'b0);
    repeat (4) tick_item();

    for (int p = 0; p < 3; p++) begin
      drain();
      case (p)
        0: set_commands(8'($urandom), 8'($urandom), 8'($urandom));
        1: set_commands(8'hFF, 8'hFF, 8'hFF);
        default: begin
          gaps_allowed = 1'b0;
          idle_on      = 1'b0;
          set_commands(8'h00, 8'h00, 8'h00);
        end
      endcase
      phase_start = n_ticks + n_loads;
      do send_frame(); while (n_ticks + n_loads - phase_start < 280);
    end

    drain();
    repeat (4) @(negedge clk);
    $display("Covered %0d items: %0d ticks and %0d digit loads, %0d register writes",
             n_ticks + n_loads, n_ticks, n_loads, n_writes);
    $display("Command sets: reset values, random, all ones, all zeros; no stalls at the end");
    if (fail_count == 0 && in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, in_flight);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
